@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files; line_rasterizer.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define ASSERT_AX(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

@@ sv/lrast_pkg.sv @@
// Types and constants for the line rasterizer.
package lrast_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int COLOR_WIDTH = 24;
    localparam int DELTA_WIDTH = COORD_WIDTH + 1;
    localparam int ERR_WIDTH   = COORD_WIDTH + 3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DELTA_WIDTH-1:0] delta_t;
    typedef logic signed [ERR_WIDTH-1:0]   err_t;
    typedef logic signed [ERR_WIDTH:0]     err2_t;
    typedef logic [COLOR_WIDTH-1:0]        color_t;

    typedef struct packed {
        logic   mode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } lrast_item_t;

    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } lrast_pix_t;

endpackage

@@ sv/line_rasterizer.sv @@
// Line rasterizer top level: input register, step logic and result register.
// A mode 0 request loads two endpoints and a colour and returns the leftmost
// endpoint; each mode 1 request returns the next Bresenham pixel, with
// last_pixel set on the far endpoint, or a result with pixel_valid low when
// no line is active. One request is taken and one result given every cycle
// while the sink takes results; a result passes through the input register
// and then the result register. s_ready drops only while the input
// register is full and the result register holds a result the sink has not
// taken. Each step is two compares and two adds on the error term.
`include "assert_macros.svh"

module line_rasterizer import lrast_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_mode,
    input  coord_t       s_start_x,
    input  coord_t       s_start_y,
    input  coord_t       s_end_x,
    input  coord_t       s_end_y,
    input  color_t       s_line_color,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_pixel_valid,
    output coord_t       m_pixel_x,
    output coord_t       m_pixel_y,
    output color_t       m_pixel_color,
    output logic         m_last_pixel
);

    lrast_item_t s_item;
    lrast_item_t item;
    logic        item_valid;
    logic        advance;
    lrast_pix_t  pix;
    lrast_pix_t  m_pix;
    logic        line_active;
    logic        fire;

    assign s_item.mode       = s_mode;
    assign s_item.start_x    = s_start_x;
    assign s_item.start_y    = s_start_y;
    assign s_item.end_x      = s_end_x;
    assign s_item.end_y      = s_end_y;
    assign s_item.line_color = s_line_color;

    assign fire = item_valid && advance;

    lrast_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lrast_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item),
        .pix         (pix),
        .line_active (line_active)
    );

    lrast_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .pix        (pix),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pix      (m_pix)
    );

    assign m_pixel_valid = m_pix.pixel_valid;
    assign m_pixel_x     = m_pix.pixel_x;
    assign m_pixel_y     = m_pix.pixel_y;
    assign m_pixel_color = m_pix.pixel_color;
    assign m_last_pixel  = m_pix.last_pixel;

    `ASSERT_AX(a_stall_only_on_output,
        !s_ready |-> (m_valid && !m_ready),
        "input stalled without output backpressure")
    `ASSERT_AX(a_last_ends_line,
        (fire && pix.last_pixel) |=> !line_active,
        "line still active after last pixel")
    `ASSERT_AX(a_last_has_pixel,
        (m_valid && m_last_pixel) |-> m_pixel_valid,
        "last pixel flagged on empty result")
    `ASSERT_AX(a_empty_is_zero,
        (m_valid && !m_pixel_valid) |-> (m_pixel_x == '0 && m_pixel_y == '0
            && m_pixel_color == '0 && !m_last_pixel),
        "empty result not cleared")

endmodule

@@ sv/lrast_in_reg.sv @@
// Input request register of the line rasterizer.
module lrast_in_reg import lrast_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lrast_item_t s_item,
    input  logic        advance,
    output logic        item_valid,
    output lrast_item_t item
);

    logic        in_valid_reg;
    logic        in_valid_next;
    lrast_item_t item_reg;

    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/lrast_core.sv @@
// Line state and one Bresenham step per request.
module lrast_core import lrast_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  lrast_item_t item,
    output lrast_pix_t  pix,
    output logic        line_active
);

    coord_t cur_x_reg, cur_y_reg, target_x_reg, target_y_reg;
    delta_t delta_x_reg, delta_y_abs_reg;
    logic   y_step_down_reg;
    err_t   error_term_reg;
    color_t held_color_reg;
    logic   line_active_reg;

    // load path
    coord_t sx, sy, ex, ey;
    coord_t ax, ay, bx, by;
    logic   swap;
    delta_t dx_load, dy_load, dyabs_load;
    logic   down_load;
    err_t   err_load;
    logic   last_load;

    // step path
    err2_t  e2, ndy2, dx2;
    err_t   dx_ext, dyabs_ext;
    logic   step_x, step_y;
    err_t   err_step;
    coord_t x_step, y_step;
    logic   last_step;

    always_comb begin
        sx = item.start_x;
        sy = item.start_y;
        ex = item.end_x;
        ey = item.end_y;
        swap = sx > ex;
        ax = swap ? ex : sx;
        ay = swap ? ey : sy;
        bx = swap ? sx : ex;
        by = swap ? sy : ey;
        dx_load = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
        dy_load = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
        down_load = dy_load[DELTA_WIDTH-1];
        dyabs_load = down_load ? -dy_load : dy_load;
        err_load = {{2{dx_load[DELTA_WIDTH-1]}}, dx_load}
                 - {{2{dyabs_load[DELTA_WIDTH-1]}}, dyabs_load};
        last_load = (ax == bx) && (ay == by);
    end

    always_comb begin
        dx_ext    = {{2{delta_x_reg[DELTA_WIDTH-1]}}, delta_x_reg};
        dyabs_ext = {{2{delta_y_abs_reg[DELTA_WIDTH-1]}}, delta_y_abs_reg};
        e2        = {error_term_reg, 1'b0};
        ndy2      = -{dyabs_ext[ERR_WIDTH-1], dyabs_ext};
        dx2       = {dx_ext[ERR_WIDTH-1], dx_ext};
        step_x    = e2 >= ndy2;
        step_y    = e2 <= dx2;
        err_step  = error_term_reg - (step_x ? dyabs_ext : '0) + (step_y ? dx_ext : '0);
        x_step    = step_x ? cur_x_reg + coord_t'(1) : cur_x_reg;
        if (!step_y) begin
            y_step = cur_y_reg;
        end else if (y_step_down_reg) begin
            y_step = cur_y_reg - coord_t'(1);
        end else begin
            y_step = cur_y_reg + coord_t'(1);
        end
        last_step = (x_step == target_x_reg) && (y_step == target_y_reg);
    end

    always_comb begin
        pix = '0;
        if (item.mode == MODE_LOAD) begin
            pix.pixel_valid = 1'b1;
            pix.pixel_x     = ax;
            pix.pixel_y     = ay;
            pix.pixel_color = item.line_color;
            pix.last_pixel  = last_load;
        end else if (line_active_reg) begin
            pix.pixel_valid = 1'b1;
            pix.pixel_x     = x_step;
            pix.pixel_y     = y_step;
            pix.pixel_color = held_color_reg;
            pix.last_pixel  = last_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            delta_y_abs_reg <= '0;
            y_step_down_reg <= 1'b0;
            error_term_reg  <= '0;
            held_color_reg  <= '0;
            line_active_reg <= 1'b0;
        end else if (fire) begin
            if (item.mode == MODE_LOAD) begin
                cur_x_reg       <= ax;
                cur_y_reg       <= ay;
                target_x_reg    <= bx;
                target_y_reg    <= by;
                delta_x_reg     <= dx_load;
                delta_y_abs_reg <= dyabs_load;
                y_step_down_reg <= down_load;
                error_term_reg  <= err_load;
                held_color_reg  <= item.line_color;
                line_active_reg <= !last_load;
            end else if (line_active_reg) begin
                cur_x_reg      <= x_step;
                cur_y_reg      <= y_step;
                error_term_reg <= err_step;
                if (last_step) begin
                    line_active_reg <= 1'b0;
                end
            end
        end
    end

    assign line_active = line_active_reg;

endmodule

@@ sv/lrast_out_reg.sv @@
// Result register of the line rasterizer.
module lrast_out_reg import lrast_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  lrast_pix_t pix,
    output logic       advance,
    output logic       m_valid,
    input  logic       m_ready,
    output lrast_pix_t m_pix
);

    logic       out_valid_reg;
    logic       out_valid_next;
    lrast_pix_t pix_reg;

    assign advance        = !out_valid_reg || m_ready;
    assign out_valid_next = (item_valid && advance) || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && advance) begin
            pix_reg <= pix;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pix   = pix_reg;

endmodule
